FILE: sv/twg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types and constants of the trapezoid wave generator.
// ----------------------------------------------------------------------------
package twg_pkg;

   localparam int STEP_BITS = 6;
   localparam int RATE_BITS = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // menu rates
   localparam logic [RATE_BITS-1:0] RATE_NONE = 3'd0;
   localparam logic [RATE_BITS-1:0] RATE_MIN  = 3'd1;
   localparam logic [RATE_BITS-1:0] RATE_2    = 3'd2;
   localparam logic [RATE_BITS-1:0] RATE_3    = 3'd3;
   localparam logic [RATE_BITS-1:0] RATE_MAX  = 3'd4;

   // ramp steps per rate
   localparam logic [STEP_BITS-1:0] STEPS_RATE1 = 6'd39;
   localparam logic [STEP_BITS-1:0] STEPS_RATE2 = 6'd19;
   localparam logic [STEP_BITS-1:0] STEPS_RATE3 = 6'd9;
   localparam logic [STEP_BITS-1:0] STEPS_RATE4 = 6'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_MS      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS_RATE1 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS_RATE2 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS_RATE3 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS_RATE4 = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_RAMP_UP   = 2'd1,
      PH_HOLD      = 2'd2,
      PH_RAMP_DOWN = 2'd3
   } phase_type;

   typedef struct packed {
      logic [15:0]      debounce_ms;
      logic [7:0]       sample_ticks;
      logic [3:0][15:0] hold_ticks;
   } cfg_type;

   function automatic logic [STEP_BITS-1:0] steps_for_rate(input logic [RATE_BITS-1:0] rate);
      logic [STEP_BITS-1:0] n;
      case (rate)
         RATE_2:  n = STEPS_RATE2;
         RATE_3:  n = STEPS_RATE3;
         RATE_MAX: n = STEPS_RATE4;
         default: n = STEPS_RATE1;
      endcase
      return n;
   endfunction

endpackage

FILE: sv/trapezoid_wave_generator_with_menu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_wave_generator_with_menu_core
// Button menu and trapezoid wave generator, one result word per tick word.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  req_    | in        | tdata[2:0] = up, down, select press
//  rsp_    | out       | tdata = level, pending rate, active rate, phase
//  csr_    | in        | index + 16-bit data, always ready
//
//  One tick word per cycle while the result is not stalled; the debounce
//  counters, menu and wave sequencer update between the input register
//  and the result register, whose load raises rsp valid.
//  A stalled result holds; the input register still takes a word while the
//  result register drains in the same cycle.
//  Synchronous active-high reset sets defaults, but not the press or result data.
// ----------------------------------------------------------------------------
module trapezoid_wave_generator_with_menu_core #(
   parameter int LEVEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // up, down, select, 5'b0
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,   // level[15:0], pending[2:0],
                                                             // active[2:0], phase[1:0]
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [twg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [twg_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import twg_pkg::*;

   cfg_type              cfg_ff;
   logic                 in_valid_ff;
   logic [2:0]           in_press_ff;
   logic                 rsp_valid_ff;
   logic [23:0]          rsp_data_ff;
   logic [RATE_BITS-1:0] pending_ff, pending_in;
   logic [RATE_BITS-1:0] active_ff, active_in;
   logic                 advance;
   logic [2:0]           accepted;
   logic [LEVEL_BITS-1:0] level;
   logic [LEVEL_BITS+15:0] level_wide;
   logic [1:0]           phase_out;
   logic [RATE_BITS-1:0] pending_up;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= 16'd1000;
         cfg_ff.sample_ticks  <= 8'd2;
         cfg_ff.hold_ticks[0] <= 16'd80;
         cfg_ff.hold_ticks[1] <= 16'd160;
         cfg_ff.hold_ticks[2] <= 16'd200;
         cfg_ff.hold_ticks[3] <= 16'd220;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:      cfg_ff.debounce_ms   <= csr_data;
            CSR_SAMPLE_TICKS:     cfg_ff.sample_ticks  <= csr_data[7:0];
            CSR_HOLD_TICKS_RATE1: cfg_ff.hold_ticks[0] <= csr_data;
            CSR_HOLD_TICKS_RATE2: cfg_ff.hold_ticks[1] <= csr_data;
            CSR_HOLD_TICKS_RATE3: cfg_ff.hold_ticks[2] <= csr_data;
            CSR_HOLD_TICKS_RATE4: cfg_ff.hold_ticks[3] <= csr_data;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   twg_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (advance),
      .press       (in_press_ff),
      .debounce_ms (cfg_ff.debounce_ms),
      .accepted    (accepted)
   );

   // menu: up first, then down, then select
   always_comb begin
      pending_up = (accepted[0] && pending_ff > RATE_MIN) ? pending_ff - 1'b1 : pending_ff;
      pending_in = (accepted[1] && pending_up < RATE_MAX) ? pending_up + 1'b1 : pending_up;
      active_in  = accepted[2] ? pending_in : active_ff;
   end

   twg_wave #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_wave (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (advance),
      .restart     (accepted[2]),
      .active_rate (active_in),
      .cfg         (cfg_ff),
      .level       (level),
      .phase_out   (phase_out)
   );

   assign level_wide = {16'd0, level};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= RATE_MIN;
         active_ff    <= RATE_NONE;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pending_ff   <= pending_in;
            active_ff    <= active_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_press_ff <= req_tdata[2:0];
      end
      if (advance) begin
         rsp_data_ff <= {phase_out, active_in, pending_in, level_wide[15:0]};
      end
   end

endmodule

FILE: sv/twg_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_debounce
// Per-button tick counters; a press passes only once the debounce time is over.
// ----------------------------------------------------------------------------
module twg_debounce (
   input  logic        clock,
   input  logic        reset,
   input  logic        tick_en,
   input  logic [2:0]  press,
   input  logic [15:0] debounce_ms,
   output logic [2:0]  accepted
);
   import twg_pkg::*;

   logic [2:0][15:0] since_ff;
   logic [2:0][15:0] since_in;

   always_comb begin
      logic [15:0] bumped;
      for (int b = 0; b < 3; b++) begin
         // saturate at the top, then test against the debounce time
         bumped = (since_ff[b] == 16'hFFFF) ? since_ff[b] : since_ff[b] + 16'd1;
         accepted[b] = press[b] && (bumped > debounce_ms);
         since_in[b] = accepted[b] ? 16'd0 : bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= '0;
      end else if (tick_en) begin
         since_ff <= since_in;
      end
   end

endmodule

FILE: sv/twg_wave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_wave
// Trapezoid sequencer: phase, step and dwell counters plus the level multiply.
// ----------------------------------------------------------------------------
module twg_wave #(
   parameter int LEVEL_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tick_en,
   input  logic                           restart,
   input  logic [twg_pkg::RATE_BITS-1:0]  active_rate,
   input  twg_pkg::cfg_type               cfg,
   output logic [LEVEL_BITS-1:0]          level,
   output logic [1:0]                     phase_out
);
   import twg_pkg::*;

   localparam longint unsigned FULL_SCALE = (64'd1 << LEVEL_BITS) - 64'd1;
   localparam longint unsigned INC_RATE1 =
      (FULL_SCALE * 10 + (11 * 39) / 2) / (11 * 39);
   localparam longint unsigned INC_RATE2 =
      (FULL_SCALE * 10 + (11 * 19) / 2) / (11 * 19);
   localparam longint unsigned INC_RATE3 =
      (FULL_SCALE * 10 + (11 * 9) / 2) / (11 * 9);
   localparam longint unsigned INC_RATE4 =
      (FULL_SCALE * 10 + (11 * 4) / 2) / (11 * 4);

   phase_type            phase_ff, phase_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [15:0]          dwell_ff, dwell_in;

   phase_type            phase_cur;
   logic [STEP_BITS-1:0] step_cur;
   logic [15:0]          dwell_cur;
   logic                 running;
   logic [STEP_BITS-1:0] n_steps;
   logic [1:0]           rate_idx;
   logic [15:0]          hold;
   logic [7:0]           samp;
   logic [15:0]          dur;
   logic [16:0]          dwell_inc;
   logic                 done;
   logic [LEVEL_BITS-1:0] inc;
   logic [STEP_BITS-1:0] mult_step;
   logic [LEVEL_BITS+STEP_BITS-1:0] product;

   // a restart puts the wave back at ramp-up step zero before this tick runs
   assign phase_cur = restart ? PH_RAMP_UP : phase_ff;
   assign step_cur  = restart ? '0 : step_ff;
   assign dwell_cur = restart ? '0 : dwell_ff;

   assign running   = (active_rate != RATE_NONE) && (phase_cur != PH_IDLE);
   assign n_steps   = steps_for_rate(active_rate);
   assign rate_idx  = 2'(active_rate - RATE_MIN);
   assign hold      = cfg.hold_ticks[rate_idx];
   assign samp      = (cfg.sample_ticks == 8'd0) ? 8'd1 : cfg.sample_ticks;
   assign dur       = (phase_cur == PH_HOLD) ? hold : {8'd0, samp};
   assign dwell_inc = {1'b0, dwell_cur} + 17'd1;
   assign done      = dwell_inc >= {1'b0, dur};

   // next state
   always_comb begin
      phase_in = phase_cur;
      step_in  = step_cur;
      dwell_in = dwell_cur;
      if (running) begin
         dwell_in = dwell_inc[15:0];
         if (done) begin
            dwell_in = '0;
            case (phase_cur)
               PH_RAMP_UP: begin
                  if (step_cur < n_steps) begin
                     step_in = step_cur + 1'b1;
                  end else begin
                     step_in  = n_steps;
                     phase_in = (hold == 16'd0) ? PH_RAMP_DOWN : PH_HOLD;
                  end
               end
               PH_HOLD: begin
                  phase_in = PH_RAMP_DOWN;
                  step_in  = n_steps;
               end
               PH_RAMP_DOWN: begin
                  if (step_cur > 1) begin
                     step_in = step_cur - 1'b1;
                  end else begin
                     phase_in = PH_RAMP_UP;
                     step_in  = '0;
                  end
               end
               default: begin
                  phase_in = phase_cur;
               end
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      case (active_rate)
         RATE_2:   inc = LEVEL_BITS'(INC_RATE2);
         RATE_3:   inc = LEVEL_BITS'(INC_RATE3);
         RATE_MAX: inc = LEVEL_BITS'(INC_RATE4);
         default:  inc = LEVEL_BITS'(INC_RATE1);
      endcase
      mult_step = (phase_cur == PH_HOLD) ? n_steps : step_cur;
      product   = mult_step * inc;
      level     = running ? product[LEVEL_BITS-1:0] : LEVEL_BITS'(FULL_SCALE);
      phase_out = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
         dwell_ff <= '0;
      end else if (tick_en) begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         dwell_ff <= dwell_in;
      end
   end

endmodule
